@@ rtl/mstd_pkg.sv @@
`timescale 1ns / 1ps

package mstd_pkg;

   localparam int FREQ_W   = 20;
   localparam int CD_W     = 22;
   localparam int MIN_W    = 14;
   localparam int SLOT_W   = 4;
   localparam int MASK_W   = 16;
   localparam int STAT_W   = 2;
   localparam int REQ_W    = 2;

   localparam int DEF_SLOTS = 16;

   localparam logic [FREQ_W-1:0] BASE_HZ      = FREQ_W'(1000000);
   localparam logic [FREQ_W-1:0] TOP_HZ       = FREQ_W'(10000);
   localparam logic [MIN_W-1:0]  DEF_MIN_FREQ = MIN_W'(1000);

   typedef enum logic [REQ_W-1:0] {
      REQ_TICK   = 2'd0,
      REQ_ATTACH = 2'd1,
      REQ_DETACH = 2'd2,
      REQ_NOP    = 2'd3
   } req_code_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK          = 2'd0,
      ST_FREQ_REJECT = 2'd1,
      ST_FULL        = 2'd2,
      ST_BAD_SLOT    = 2'd3
   } status_type;

   typedef struct packed {
      logic signed [CD_W-1:0] countdown;
      logic [FREQ_W-1:0]      period;
   } slot_entry_type;

endpackage

@@ rtl/mstd_if.sv @@
`timescale 1ns / 1ps

interface mstd_req_if;
   import mstd_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [REQ_W-1:0]       req_type;
   logic [FREQ_W-1:0]      frequency;
   logic [SLOT_W-1:0]      slot;

   modport source (output valid, req_type, frequency, slot, input ready);
   modport sink   (input valid, req_type, frequency, slot, output ready);
endinterface

interface mstd_rsp_if;
   import mstd_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [MASK_W-1:0]      fire_mask;
   logic [SLOT_W-1:0]      slot_index;
   logic [STAT_W-1:0]      status;

   modport source (output valid, fire_mask, slot_index, status, input ready);
   modport sink   (input valid, fire_mask, slot_index, status, output ready);
endinterface

@@ rtl/mstd_div.sv @@
`timescale 1ns / 1ps

module mstd_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [mstd_pkg::FREQ_W-1:0] divisor,
   output logic                        done,
   output logic [mstd_pkg::FREQ_W-1:0] quotient
);
   import mstd_pkg::*;

   localparam int STEP_W = $clog2(FREQ_W);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [FREQ_W-1:0]   quo_ff, quo_in;
   logic [FREQ_W:0]     rem_ff, rem_in;
   logic [FREQ_W-1:0]   div_ff, div_in;
   logic [FREQ_W:0]     trial;
   logic [FREQ_W:0]     diff;

   // one restoring step per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      trial   = {rem_ff[FREQ_W-1:0], quo_ff[FREQ_W-1]};
      diff    = trial - {1'b0, div_ff};
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         quo_in  = BASE_HZ;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         if (!diff[FREQ_W]) begin
            rem_in = diff;
            quo_in = {quo_ff[FREQ_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[FREQ_W-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(FREQ_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ rtl/multi_slot_periodic_tick_divider_top.sv @@
`timescale 1ns / 1ps
// attach: check, 20-step serial divide, response load
// tick: one slot table read and write-back per cycle
// detach, rejected attach and other requests: check, then response load; one transaction in flight at a time
// the response register lets the next request be taken while a result waits
// reset (synchronous): no slots live, slot count, rate and interval cleared,
// rate floor back to 1000; slot table contents are not cleared

module multi_slot_periodic_tick_divider_top #(
   parameter int SLOTS = mstd_pkg::DEF_SLOTS
) (
   input  logic                       clock,
   input  logic                       reset,
   mstd_req_if.sink                   req,
   mstd_rsp_if.source                 rsp,
   input  logic                       csr_wr_en,
   input  logic [mstd_pkg::MIN_W-1:0] csr_wr_data
);
   import mstd_pkg::*;

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam int CW    = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;
   localparam int MW    = CW + 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_DIV,
      S_TICK,
      S_RESP
   } state_type;

   state_type              state_ff, state_in;
   req_code_type           op_ff, op_in;
   logic [FREQ_W-1:0]      freq_ff, freq_in;
   logic [SLOT_W-1:0]      slot_ff, slot_in;
   logic [MIN_W-1:0]       min_freq_ff;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [MIN_W-1:0]       top_ff, top_in;
   logic [FREQ_W-1:0]      interval_ff, interval_in;
   logic [SLOTS-1:0]       live_ff, live_in;
   logic [CNT_W-1:0]       idx_ff, idx_in;
   logic                   rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0]       rd_idx_ff, rd_idx_in;
   logic [MASK_W-1:0]      mask_ff, mask_in;
   logic [SLOT_W-1:0]      index_ff, index_in;
   status_type             status_ff, status_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [MASK_W-1:0]      rsp_mask_ff, rsp_mask_in;
   logic [SLOT_W-1:0]      rsp_index_ff, rsp_index_in;
   status_type             rsp_status_ff, rsp_status_in;

   slot_entry_type         slot_mem [SLOTS];
   slot_entry_type         rd_data_ff;
   logic                   mem_we;
   logic [IDX_W-1:0]       mem_wa;
   slot_entry_type         mem_wd;
   logic                   rd_en;

   logic                   div_start;
   logic                   div_done;
   logic [FREQ_W-1:0]      div_quo;

   logic [CW-1:0]          cnt_ext;
   logic [CW-1:0]          slot_ext;
   logic [MW-1:0]          rd_idx_ext;
   logic                   issue;
   logic signed [CD_W-1:0] cd_diff;
   logic signed [CD_W-1:0] cd_next;
   logic                   raise;

   mstd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (freq_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign cnt_ext    = CW'(cnt_ff);
   assign slot_ext   = CW'(slot_ff);
   assign rd_idx_ext = MW'(rd_idx_ff);
   assign issue      = idx_ff < cnt_ff;
   assign raise      = freq_ff > FREQ_W'(top_ff);
   assign cd_diff    = rd_data_ff.countdown - $signed(CD_W'(interval_ff));
   assign cd_next    = cd_diff[CD_W-1] ? cd_diff + $signed(CD_W'(rd_data_ff.period))
                                       : cd_diff;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      freq_in       = freq_ff;
      slot_in       = slot_ff;
      cnt_in        = cnt_ff;
      top_in        = top_ff;
      interval_in   = interval_ff;
      live_in       = live_ff;
      idx_in        = idx_ff;
      rd_valid_in   = 1'b0;
      rd_idx_in     = rd_idx_ff;
      mask_in       = mask_ff;
      index_in      = index_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_mask_in   = rsp_mask_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_status_in = rsp_status_ff;
      mem_we        = 1'b0;
      mem_wa        = cnt_ff[IDX_W-1:0];
      mem_wd        = '{countdown: $signed(CD_W'(div_quo)), period: div_quo};
      rd_en         = 1'b0;
      div_start     = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               op_in     = req_code_type'(req.req_type);
               freq_in   = req.frequency;
               slot_in   = req.slot;
               mask_in   = '0;
               index_in  = '0;
               status_in = ST_OK;
               idx_in    = '0;
               state_in  = S_CHECK;
            end
         end
         S_CHECK: begin
            case (op_ff)
               REQ_TICK: begin
                  state_in = S_TICK;
               end
               REQ_ATTACH: begin
                  if (freq_ff == '0) begin
                     status_in = ST_FREQ_REJECT;
                     state_in  = S_RESP;
                  end else if (cnt_ff >= CNT_W'(SLOTS)) begin
                     status_in = ST_FULL;
                     state_in  = S_RESP;
                  end else if (raise && (freq_ff < FREQ_W'(min_freq_ff) ||
                                         freq_ff > TOP_HZ)) begin
                     status_in = ST_FREQ_REJECT;
                     state_in  = S_RESP;
                  end else begin
                     div_start = 1'b1;
                     state_in  = S_DIV;
                  end
               end
               REQ_DETACH: begin
                  if (slot_ext >= cnt_ext) begin
                     status_in = ST_BAD_SLOT;
                  end else begin
                     live_in[slot_ext[IDX_W-1:0]] = 1'b0;
                  end
                  state_in = S_RESP;
               end
               default: begin
                  state_in = S_RESP;
               end
            endcase
         end
         S_DIV: begin
            if (div_done) begin
               mem_we                       = 1'b1;
               live_in[cnt_ff[IDX_W-1:0]]   = 1'b1;
               if (raise) begin
                  interval_in = div_quo;
                  top_in      = freq_ff[MIN_W-1:0];
               end
               index_in = cnt_ext[SLOT_W-1:0];
               cnt_in   = cnt_ff + 1'b1;
               state_in = S_RESP;
            end
         end
         S_TICK: begin
            // read slot idx while writing back the slot read in the previous cycle
            if (issue) begin
               rd_en       = 1'b1;
               rd_idx_in   = idx_ff[IDX_W-1:0];
               idx_in      = idx_ff + 1'b1;
               rd_valid_in = 1'b1;
            end
            if (rd_valid_ff) begin
               mem_we = 1'b1;
               mem_wa = rd_idx_ff;
               mem_wd = '{countdown: cd_next, period: rd_data_ff.period};
               if (cd_diff[CD_W-1] && live_ff[rd_idx_ff] &&
                   rd_idx_ext < MW'(MASK_W)) begin
                  mask_in[rd_idx_ext[SLOT_W-1:0]] = 1'b1;
               end
            end
            if (!issue && !rd_valid_ff) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_mask_in   = mask_ff;
               rsp_index_in  = index_ff;
               rsp_status_in = status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         min_freq_ff  <= DEF_MIN_FREQ;
         cnt_ff       <= '0;
         top_ff       <= '0;
         interval_ff  <= '0;
         live_ff      <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_wr_en) begin
            min_freq_ff <= csr_wr_data;
         end
         cnt_ff       <= cnt_in;
         top_ff       <= top_in;
         interval_ff  <= interval_in;
         live_ff      <= live_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      freq_ff       <= freq_in;
      slot_ff       <= slot_in;
      idx_ff        <= idx_in;
      rd_idx_ff     <= rd_idx_in;
      mask_ff       <= mask_in;
      index_ff      <= index_in;
      status_ff     <= status_in;
      rsp_mask_ff   <= rsp_mask_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_status_ff <= rsp_status_in;
   end

   // slot table
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_wa] <= mem_wd;
      end
      if (rd_en) begin
         rd_data_ff <= slot_mem[idx_ff[IDX_W-1:0]];
      end
   end

   assign req.ready      = (state_ff == S_IDLE);
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.fire_mask  = rsp_mask_ff;
   assign rsp.slot_index = rsp_index_ff;
   assign rsp.status     = rsp_status_ff;

   a_attach_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && div_done) |=> cnt_ff == $past(cnt_ff) + 1'b1)
      else $error("attach did not advance slot count");

   a_interval_set: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != '0) |-> (interval_ff != '0 && top_ff != '0))
      else $error("slots attached without a tick interval");

   a_rate_cap: assert property (@(posedge clock) disable iff (reset)
      FREQ_W'(top_ff) <= TOP_HZ)
      else $error("top frequency above limit");

   a_err_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_OK) |->
         (rsp_mask_ff == '0 && rsp_index_ff == '0))
      else $error("rejected transaction carries payload");

endmodule

@@ verif/tick_divider_checker.sv @@
`timescale 1ns / 1ps

module tick_divider_checker (
   input  logic                       clock,
   input  logic                       reset,
   mstd_req_if                        req_mon,
   mstd_rsp_if                        rsp_mon,
   input  logic                       csr_wr_en,
   input  logic [mstd_pkg::MIN_W-1:0] csr_wr_data,
   input  logic                       final_check,
   output int                         fail_count
);
   import mstd_pkg::*;

   localparam int SLOTS       = DEF_SLOTS;
   localparam int PRINT_LIMIT = 40;

   typedef struct packed {
      logic [MASK_W-1:0] fire_mask;
      logic [SLOT_W-1:0] slot_index;
      status_type        status;
   } timer_answer_type;

   slot_entry_type    slot_table [SLOTS];
   logic [SLOTS-1:0]  slot_live;
   logic [SLOT_W:0]   slot_count;
   logic [MIN_W-1:0]  rate_floor;
   logic [MIN_W-1:0]  top_frequency;
   logic [FREQ_W-1:0] tick_interval;
   timer_answer_type  awaited_answers [$];
   bit                final_done;

   initial begin
      fail_count = 0;
      final_done = 1'b0;
   end

   task automatic flag_mismatch(string what, int got, int want);
      fail_count++;
      if (fail_count <= PRINT_LIMIT)
         $display("%0t: %s, got 0x%0h, expected 0x%0h", $time, what, got, want);
   endtask

   function automatic timer_answer_type advance_slot_table(logic [REQ_W-1:0] op,
                                                           logic [FREQ_W-1:0] freq,
                                                           logic [SLOT_W-1:0] sel);
      timer_answer_type  ans;
      int                level;
      logic [FREQ_W-1:0] period;
      ans = '0;
      case (op)
         REQ_TICK: begin
            for (int i = 0; i < slot_count; i++) begin
               level = int'(slot_table[i].countdown) - int'(tick_interval);
               if (level < 0) begin
                  level += int'(slot_table[i].period);
                  if (slot_live[i] && i < MASK_W)
                     ans.fire_mask[i] = 1'b1;
               end
               slot_table[i].countdown = level[CD_W-1:0];
            end
         end
         REQ_ATTACH: begin
            if (freq == '0)
               ans.status = ST_FREQ_REJECT;
            else if (slot_count >= SLOTS)
               ans.status = ST_FULL;
            else if (freq > FREQ_W'(top_frequency) &&
                     (freq < FREQ_W'(rate_floor) || freq > TOP_HZ))
               ans.status = ST_FREQ_REJECT;
            else begin
               period = BASE_HZ / freq;
               // a faster slot sets the shared tick interval
               if (freq > FREQ_W'(top_frequency)) begin
                  tick_interval = period;
                  top_frequency = freq[MIN_W-1:0];
               end
               slot_table[slot_count].countdown = CD_W'(period);
               slot_table[slot_count].period    = period;
               slot_live[slot_count]            = 1'b1;
               ans.slot_index                   = slot_count[SLOT_W-1:0];
               slot_count++;
            end
         end
         REQ_DETACH: begin
            if ({1'b0, sel} >= slot_count)
               ans.status = ST_BAD_SLOT;
            else
               slot_live[sel] = 1'b0;
         end
         default: ;
      endcase
      return ans;
   endfunction

   always @(posedge clock) begin
      timer_answer_type want;
      timer_answer_type next_answer;
      if (reset) begin
         slot_live     = '0;
         slot_count    = '0;
         rate_floor    = DEF_MIN_FREQ;
         top_frequency = '0;
         tick_interval = '0;
         awaited_answers.delete();
      end else begin
         if (csr_wr_en)
            rate_floor = csr_wr_data;
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            if (awaited_answers.size() == 0) begin
               flag_mismatch("response transaction with none awaited",
                             int'(rsp_mon.fire_mask), 0);
            end else begin
               want = awaited_answers.pop_front();
               if (rsp_mon.fire_mask !== want.fire_mask)
                  flag_mismatch("fire_mask", int'(rsp_mon.fire_mask), int'(want.fire_mask));
               if (rsp_mon.slot_index !== want.slot_index)
                  flag_mismatch("slot_index", int'(rsp_mon.slot_index),
                                int'(want.slot_index));
               if (rsp_mon.status !== want.status)
                  flag_mismatch("status", int'(rsp_mon.status), int'(want.status));
            end
         end
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) begin
            next_answer     = advance_slot_table(req_mon.req_type, req_mon.frequency,
                                                 req_mon.slot);
            awaited_answers = {awaited_answers, next_answer};
         end
         if (final_check && !final_done) begin
            final_done = 1'b1;
            foreach (awaited_answers[i])
               flag_mismatch("response transaction never arrived", 0, i);
         end
      end
   end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
   import mstd_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int HOLD_OFF     = 400;
   localparam int HOLD_AT      = 300;
   localparam int DRAIN_TAIL   = 30;
   localparam int PHASE_ITEMS  = 270;

   logic             clock = 1'b0;
   logic             reset;
   logic             csr_wr_en;
   logic [MIN_W-1:0] csr_wr_data;
   logic             final_check;
   int               fail_count;
   int               sent_count  = 0;
   int               got_count   = 0;
   int               cycle_count = 0;
   bit               steady      = 1'b0;

   mstd_req_if req_bus ();
   mstd_rsp_if rsp_bus ();

   multi_slot_periodic_tick_divider_top dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_bus),
      .rsp         (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   tick_divider_checker u_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .final_check (final_check),
      .fail_count  (fail_count)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic int idle_gap();
      return steady ? 0 : $urandom_range(0, 10);
   endfunction

   task automatic send_item(req_code_type op, logic [FREQ_W-1:0] freq,
                            logic [SLOT_W-1:0] sel);
      int gap;
      gap = idle_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.req_type  <= op;
      req_bus.frequency <= freq;
      req_bus.slot      <= sel;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      sent_count++;
   endtask

   task automatic settle_and_set_min(logic [MIN_W-1:0] value);
      req_bus.valid <= 1'b0;
      while (got_count != sent_count) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic send_random_item();
      int                pick;
      logic [FREQ_W-1:0] freq;
      req_code_type      op;
      pick = $urandom_range(0, 99);
      freq = FREQ_W'($urandom);
      if (pick < 60)
         op = REQ_TICK;
      else if (pick < 80)
         op = REQ_ATTACH;
      else if (pick < 95)
         op = REQ_DETACH;
      else
         op = REQ_NOP;
      if (op == REQ_ATTACH) begin
         pick = $urandom_range(0, 99);
         // remaining picks keep the full-width random frequency
         if (pick >= 95)
            freq = '0;
         else if (pick < 55)
            freq = FREQ_W'($urandom_range(100, 10000));
         else if (pick < 70)
            freq = FREQ_W'($urandom_range(1, 99));
         else if (pick < 85)
            freq = FREQ_W'($urandom_range(10001, 1000000));
      end
      send_item(op, freq, SLOT_W'($urandom));
   endtask

   initial begin : response_sink
      int gap;
      bit held;
      held = 1'b0;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         gap = idle_gap();
         if (got_count == HOLD_AT && !held) begin
            held = 1'b1;
            gap  = HOLD_OFF;
         end
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock);
         while (!(rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1));
         got_count++;
      end
   end

   initial begin : stimulus
      reset             <= 1'b1;
      csr_wr_en         <= 1'b0;
      csr_wr_data       <= DEF_MIN_FREQ;
      final_check       <= 1'b0;
      req_bus.valid     <= 1'b0;
      req_bus.req_type  <= REQ_NOP;
      req_bus.frequency <= '0;
      req_bus.slot      <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // empty table, zero and out-of-range rates, slower slots
      send_item(REQ_TICK, '0, '0);
      send_item(REQ_ATTACH, '0, '0);
      send_item(REQ_ATTACH, FREQ_W'(500), '0);
      send_item(REQ_ATTACH, FREQ_W'(1000), '0);
      send_item(REQ_ATTACH, FREQ_W'(1), '0);
      send_item(REQ_ATTACH, FREQ_W'(999), '0);
      send_item(REQ_TICK, '0, '0);
      send_item(REQ_DETACH, '0, SLOT_W'(1));
      send_item(REQ_DETACH, '0, SLOT_W'(3));
      send_item(REQ_DETACH, '0, SLOT_W'(15));
      send_item(REQ_NOP, '1, '1);
      send_item(REQ_TICK, '1, '1);

      settle_and_set_min(MIN_W'(1));
      send_item(REQ_ATTACH, FREQ_W'(1600), '0);
      send_item(REQ_ATTACH, FREQ_W'(2), '0);
      send_item(REQ_TICK, '0, '0);

      settle_and_set_min(MIN_W'(10000));
      send_item(REQ_ATTACH, FREQ_W'(2000), '0);
      send_item(REQ_ATTACH, FREQ_W'(10001), '0);
      send_item(REQ_ATTACH, '1, '0);
      send_item(REQ_ATTACH, FREQ_W'(1000000), '0);
      send_item(REQ_ATTACH, FREQ_W'(10000), '0);
      send_item(REQ_TICK, '0, '0);
      send_item(REQ_TICK, '0, '0);
      send_item(REQ_DETACH, '0, '0);
      send_item(REQ_TICK, '0, '0);

      for (int phase = 0; phase < 4; phase++) begin
         if (phase == 0)
            settle_and_set_min(MIN_W'(10000));
         else if (phase == 2)
            settle_and_set_min(MIN_W'(1));
         else
            settle_and_set_min(MIN_W'($urandom_range(1, 10000)));
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 45 == 0)
               steady = ($urandom_range(0, 2) == 0);
            send_random_item();
         end
      end

      req_bus.valid <= 1'b0;
      while (got_count != sent_count) @(posedge clock);
      repeat (DRAIN_TAIL) @(posedge clock);
      final_check <= 1'b1;
      repeat (2) @(posedge clock);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
